// ===== sv/sme_pkg.sv =====
package sme_pkg;

  localparam int MODE_W = 2;
  localparam int FIELD_W = 4;
  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
  // results per run are capped by the 4-bit index fields
  localparam int MAX_RESULTS = 16;

  localparam logic [MODE_W-1:0] MODE_LOAD_PROP = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LOAD_ACC  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START     = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_LIST,
    ST_RANK_P,
    ST_RANK_C,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/sme_if.sv =====
interface sme_in_if;
  logic                         valid;
  logic                         ready;
  logic [sme_pkg::MODE_W-1:0]   mode;
  logic [sme_pkg::FIELD_W-1:0]  row;
  logic [sme_pkg::FIELD_W-1:0]  position;
  logic [sme_pkg::FIELD_W-1:0]  element;

  modport source (output valid, mode, row, position, element, input ready);
  modport sink (input valid, mode, row, position, element, output ready);
endinterface

interface sme_out_if;
  logic                         valid;
  logic                         ready;
  logic [sme_pkg::FIELD_W-1:0]  acceptor_index;
  logic [sme_pkg::FIELD_W-1:0]  matched_proposer;
  logic                         last;

  modport source (output valid, acceptor_index, matched_proposer, last, input ready);
  modport sink (input valid, acceptor_index, matched_proposer, last, output ready);
endinterface

interface sme_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sme_pkg::SIZE_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== sv/sme_ram.sv =====
module sme_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/stable_matching_engine.sv =====
// Channel  Dir  Beat payload                                   Accepted when
// cfg_ch   in   data = set_size                                cfg_ch.valid & cfg_ch.ready
// in_ch    in   mode, row, position, element                   in_ch.valid & in_ch.ready
// out_ch   out  acceptor_index, matched_proposer, last         out_ch.valid & out_ch.ready
//
// A start beat runs up to n*n proposals, each a pick and a list read (free acceptor or
// choice outside the set) plus two rank reads when contested (one rank memory port),
// then a pick that finds no proposer left, then one result per acceptor.
// in_ch.ready is high only between runs; cfg_ch is always ready.
// Synchronous active-low reset; the preference memories are not cleared.
// Results stall in the output register while out_ch.ready is low.
module stable_matching_engine #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  sme_cfg_if.sink        cfg_ch,
  sme_in_if.sink         in_ch,
  sme_out_if.source      out_ch
);

  localparam int SL = (MAX_ELEMENTS < sme_pkg::MAX_RESULTS) ? MAX_ELEMENTS
                                                            : sme_pkg::MAX_RESULTS;
  localparam int SW = $clog2(SL);
  localparam int NW = $clog2(SL + 1);
  localparam int TD = MAX_ELEMENTS * MAX_ELEMENTS;
  localparam int AW = $clog2(TD);
  localparam int FW = sme_pkg::FIELD_W;
  localparam int CW = sme_pkg::SIZE_W;

  sme_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] set_size_r, set_size_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic [SL-1:0] free_r, free_nxt;
  logic [SL-1:0] held_r, held_nxt;
  logic [NW-1:0] next_r [SL];
  logic [NW-1:0] next_nxt [SL];
  logic [SW-1:0] match_r [SL];
  logic [SW-1:0] match_nxt [SL];
  logic [SW-1:0] p_r, p_nxt;
  logic [SW-1:0] a_r, a_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic [FW-1:0] rank_p_r, rank_p_nxt;
  logic [SW-1:0] emit_r, emit_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [FW-1:0] out_acc_r, out_acc_nxt;
  logic [FW-1:0] out_prop_r, out_prop_nxt;
  logic          out_last_r, out_last_nxt;

  logic          in_fire, cfg_fire, load_ok;
  logic [SL-1:0] in_set, cand;
  logic          any_cand;
  logic [SW-1:0] pick;
  logic [NW-1:0] np;
  logic [FW-1:0] list_rdata, rank_rdata;
  logic [AW-1:0] list_raddr, rank_raddr;
  logic          list_we, rank_we;
  logic [AW-1:0] list_waddr, rank_waddr;
  logic          a_ok;
  logic [SW-1:0] a_idx;
  logic          rank_better;
  logic          emit_last, out_load;
  logic [NW-1:0] n_start;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = (state_r == sme_pkg::ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid            = out_valid_r;
  assign out_ch.acceptor_index   = out_acc_r;
  assign out_ch.matched_proposer = out_prop_r;
  assign out_ch.last             = out_last_r;

  // loads outside the table are dropped
  assign load_ok = (int'(in_ch.row) < MAX_ELEMENTS) && (int'(in_ch.position) < MAX_ELEMENTS)
                && (int'(in_ch.element) < MAX_ELEMENTS);

  assign list_we    = in_fire && load_ok && (in_ch.mode == sme_pkg::MODE_LOAD_PROP);
  assign rank_we    = in_fire && load_ok && (in_ch.mode == sme_pkg::MODE_LOAD_ACC);
  assign list_waddr = AW'(in_ch.row) * AW'(MAX_ELEMENTS) + AW'(in_ch.position);
  assign rank_waddr = AW'(in_ch.row) * AW'(MAX_ELEMENTS) + AW'(in_ch.element);

  always_comb begin
    n_start = NW'(set_size_r);
    if (set_size_r == '0) begin
      n_start = NW'(1);
    end else if (int'(set_size_r) > SL) begin
      n_start = NW'(SL);
    end
  end

  // lowest free proposer that still has choices
  always_comb begin
    for (int i = 0; i < SL; i++) begin
      in_set[i] = (i < int'(n_r));
      cand[i]   = free_r[i] && in_set[i] && (next_r[i] < n_r);
    end
  end

  always_comb begin
    pick = '0;
    for (int i = SL - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = SW'(i);
      end
    end
  end

  assign any_cand   = |cand;
  assign np         = next_r[pick];
  assign list_raddr = AW'(pick) * AW'(MAX_ELEMENTS) + AW'(np);

  assign a_ok  = (CW'(list_rdata) < CW'(n_r));
  assign a_idx = SW'(list_rdata);

  // first read is the newcomer's rank, second the current holder's
  assign rank_raddr = (state_r == sme_pkg::ST_LIST)
                    ? AW'(a_idx) * AW'(MAX_ELEMENTS) + AW'(p_r)
                    : AW'(a_r) * AW'(MAX_ELEMENTS) + AW'(cur_r);
  assign rank_better = (rank_p_r < rank_rdata);

  assign emit_last = ((CW'(emit_r) + CW'(1)) == CW'(n_r));
  assign out_load  = (state_r == sme_pkg::ST_EMIT) && (!out_valid_r || out_ch.ready);

  sme_ram #(.WIDTH(FW), .DEPTH(TD)) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (in_ch.element),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  sme_ram #(.WIDTH(FW), .DEPTH(TD)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rank_waddr),
    .wdata (in_ch.position),
    .raddr (rank_raddr),
    .rdata (rank_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sme_pkg::ST_IDLE: begin
        if (in_fire && (in_ch.mode == sme_pkg::MODE_START)) begin
          state_nxt = sme_pkg::ST_PICK;
        end
      end
      sme_pkg::ST_PICK: begin
        state_nxt = any_cand ? sme_pkg::ST_LIST : sme_pkg::ST_EMIT;
      end
      sme_pkg::ST_LIST: begin
        if (a_ok && held_r[a_idx]) begin
          state_nxt = sme_pkg::ST_RANK_P;
        end else begin
          state_nxt = sme_pkg::ST_PICK;
        end
      end
      sme_pkg::ST_RANK_P: state_nxt = sme_pkg::ST_RANK_C;
      sme_pkg::ST_RANK_C: state_nxt = sme_pkg::ST_PICK;
      sme_pkg::ST_EMIT: begin
        if (out_load && emit_last) begin
          state_nxt = sme_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sme_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    set_size_nxt = cfg_fire ? cfg_ch.data : set_size_r;
    n_nxt        = n_r;
    free_nxt     = free_r;
    held_nxt     = held_r;
    next_nxt     = next_r;
    match_nxt    = match_r;
    p_nxt        = p_r;
    a_nxt        = a_r;
    cur_nxt      = cur_r;
    rank_p_nxt   = rank_p_r;
    emit_nxt     = emit_r;

    case (state_r)
      sme_pkg::ST_IDLE: begin
        if (in_fire && (in_ch.mode == sme_pkg::MODE_START)) begin
          n_nxt    = n_start;
          free_nxt = '1;
          held_nxt = '0;
          for (int i = 0; i < SL; i++) begin
            next_nxt[i] = '0;
          end
        end
      end
      sme_pkg::ST_PICK: begin
        emit_nxt = '0;
        if (any_cand) begin
          p_nxt          = pick;
          next_nxt[pick] = np + NW'(1);
        end
      end
      sme_pkg::ST_LIST: begin
        if (a_ok) begin
          if (!held_r[a_idx]) begin
            held_nxt[a_idx]  = 1'b1;
            match_nxt[a_idx] = p_r;
            free_nxt[p_r]    = 1'b0;
          end else begin
            a_nxt   = a_idx;
            cur_nxt = match_r[a_idx];
          end
        end
      end
      sme_pkg::ST_RANK_P: begin
        rank_p_nxt = rank_rdata;
      end
      sme_pkg::ST_RANK_C: begin
        // ties keep the current holder
        if (rank_better) begin
          match_nxt[a_r] = p_r;
          free_nxt[p_r]  = 1'b0;
          free_nxt[cur_r] = 1'b1;
        end
      end
      sme_pkg::ST_EMIT: begin
        if (out_load && !emit_last) begin
          emit_nxt = emit_r + SW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_acc_nxt   = out_acc_r;
    out_prop_nxt  = out_prop_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_acc_nxt   = FW'(emit_r);
      out_prop_nxt  = held_r[emit_r] ? FW'(match_r[emit_r]) : '0;
      out_last_nxt  = emit_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sme_pkg::ST_IDLE;
      set_size_r  <= sme_pkg::SIZE_RESET;
      n_r         <= '0;
      free_r      <= '1;
      held_r      <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < SL; i++) begin
        next_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      set_size_r  <= set_size_nxt;
      n_r         <= n_nxt;
      free_r      <= free_nxt;
      held_r      <= held_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      next_r      <= next_nxt;
    end
  end

  always_ff @(posedge clk) begin
    match_r    <= match_nxt;
    p_r        <= p_nxt;
    a_r        <= a_nxt;
    cur_r      <= cur_nxt;
    rank_p_r   <= rank_p_nxt;
    out_acc_r  <= out_acc_nxt;
    out_prop_r <= out_prop_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef NO_ASSERTIONS
  // outside idle, held acceptors plus free proposers in the set add up to the set size
  a_match_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != sme_pkg::ST_IDLE) |->
      ($countones(held_r) + $countones(free_r & in_set) == int'(n_r)))
    else $error("held and free counts disagree with set size");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sme_pkg::ST_EMIT) |-> (CW'(emit_r) < CW'(n_r)))
    else $error("result index beyond set size");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_ch.acceptor_index) && $stable(out_ch.matched_proposer)
       && $stable(out_ch.last)))
    else $error("stalled result beat changed");

  a_start_init: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_ch.mode == sme_pkg::MODE_START)) |=>
      ((held_r == '0) && (state_r == sme_pkg::ST_PICK)))
    else $error("run did not start from a cleared matching");
`endif

endmodule
